// ===== src/dqs_pkg.sv =====
// Shared types and constants for the double-ended queue with value search.
// Used by dqs_cell and deque_with_value_search. No dependencies.
`timescale 1ns / 1ps

package dqs_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_BACK   = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_REMOVE     = 3'd4,
        ACT_FIND       = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // what a cell does with its contents on this edge
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_TAKE_PREV = 2'd2,
        CELL_TAKE_NEXT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [VALUE_BITS-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        t_action     action;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] popped_value;
        logic [3:0]  position;
        logic [4:0]  entry_count;
    } t_rsp;

endpackage

// ===== src/dqs_cell.sv =====
// One storage cell of the queue: holds one entry, compares it with the key,
// and loads from the key or from either neighbor. Depends on dqs_pkg.
`timescale 1ns / 1ps

module dqs_cell (
    input  logic                             i_clk,
    input  dqs_pkg::t_cell_ctl               i_ctl,
    input  logic [dqs_pkg::VALUE_BITS-1:0]   i_prev_value,
    input  logic [dqs_pkg::VALUE_BITS-1:0]   i_next_value,
    output logic [dqs_pkg::VALUE_BITS-1:0]   o_value,
    output logic                             o_match
);
    import dqs_pkg::*;

    logic [VALUE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_LOAD:      r_value <= i_ctl.key;
            CELL_TAKE_PREV: r_value <= i_prev_value;
            CELL_TAKE_NEXT: r_value <= i_next_value;
            default:        r_value <= r_value;
        endcase
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_ctl.key);

endmodule

// ===== src/deque_with_value_search.sv =====
// Bounded double-ended queue with value search, built as a row of cells.
// Each request is captured in IDLE and runs in the cells in EXEC; EXEC waits while the
// output register holds a stalled result, and the result is registered as EXEC ends.
// No new request is taken until EXEC has finished (capture, then compare-and-shift in the cells).
// Reset (sync, active low) clears the entry count, the sequencer and the output valid;
// cell contents and the output payload stay undefined and are never read before written.
// Depends on dqs_pkg and dqs_cell.
`timescale 1ns / 1ps

module deque_with_value_search (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  dqs_pkg::t_req   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dqs_pkg::t_rsp   o_out
);
    import dqs_pkg::*;

    // Two-step sequencer: IDLE takes a transfer, EXEC runs it in the cells
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state     r_state, n_state;
    t_req       r_req;
    logic [CNT_W-1:0] r_count, n_count;
    t_rsp       r_out, n_out;
    logic       r_out_valid, n_out_valid;

    // cell row wiring
    t_cell_ctl             w_ctl   [DEPTH];
    t_cell_op              w_op    [DEPTH];
    logic [VALUE_BITS-1:0] w_value [DEPTH];
    logic [DEPTH-1:0]      w_match;
    logic [DEPTH-1:0]      w_hit;

    logic                  w_found;
    logic [IDX_W-1:0]      w_at;
    logic [VALUE_BITS-1:0] w_key;
    logic [VALUE_BITS-1:0] w_back_value;
    logic [CNT_W-1:0]      w_count_next;
    t_rsp                  w_res;
    logic                  w_out_free;
    logic                  w_commit;

    assign w_key = r_req.value[VALUE_BITS-1:0];

    // ---------------------------------------------------------------
    // Cell row: cell 0 is the front. Each cell sees both neighbors; the ends see
    // their own value (never taken at the front; the back cell may take it and keep its value).
    // ---------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_prev, w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_value[g];
        end else begin : g_mid_p
            assign w_prev = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_value[g];
        end else begin : g_mid_n
            assign w_next = w_value[g+1];
        end

        assign w_ctl[g].op  = w_commit ? w_op[g] : CELL_HOLD;
        assign w_ctl[g].key = w_key;

        dqs_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[g]),
            .i_prev_value (w_prev),
            .i_next_value (w_next),
            .o_value      (w_value[g]),
            .o_match      (w_match[g])
        );

        // only occupied cells may report a hit
        assign w_hit[g] = w_match[g] && (CNT_W'(g) < r_count);
    end

    // first hit from the front
    always_comb begin
        w_found = 1'b0;
        w_at    = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_found = 1'b1;
                w_at    = IDX_W'(i);
            end
        end
    end

    assign w_back_value = w_value[IDX_W'(r_count - CNT_W'(1))];

    // ---------------------------------------------------------------
    // Request decode: per-cell moves, new count and the result
    // ---------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_op[i] = CELL_HOLD;
        end
        w_count_next       = r_count;
        w_res.status       = ST_OK;
        w_res.popped_value = '0;
        w_res.position     = '0;

        case (r_req.action)
            ACT_PUSH_BACK: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    w_res.status = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == r_count) begin
                            w_op[i] = CELL_LOAD;
                        end
                    end
                    w_count_next = r_count + CNT_W'(1);
                end
            end
            ACT_POP_BACK: begin
                if (r_count == '0) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_res.popped_value = 32'(w_back_value);
                    w_count_next       = r_count - CNT_W'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    w_res.status = ST_FULL;
                end else begin
                    // everything slides back one place, key enters at the front
                    w_op[0] = CELL_LOAD;
                    for (int i = 1; i < DEPTH; i++) begin
                        w_op[i] = CELL_TAKE_PREV;
                    end
                    w_count_next = r_count + CNT_W'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (r_count == '0) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        w_op[i] = CELL_TAKE_NEXT;
                    end
                    w_count_next = r_count - CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (r_count == '0) begin
                    w_res.status = ST_EMPTY;
                end else if (!w_found) begin
                    w_res.status = ST_NOT_FOUND;
                end else begin
                    // close the gap from the hit onward
                    for (int i = 0; i < DEPTH; i++) begin
                        if (IDX_W'(i) >= w_at) begin
                            w_op[i] = CELL_TAKE_NEXT;
                        end
                    end
                    w_count_next = r_count - CNT_W'(1);
                end
            end
            ACT_FIND: begin
                if (w_found) begin
                    w_res.position = 4'(w_at);
                end else begin
                    w_res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                // unused codes: list untouched, status ok
            end
        endcase

        w_res.entry_count = 5'(w_count_next);
    end

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_commit   = (r_state == S_EXEC) && w_out_free;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_count     = w_count_next;
                    n_out       = w_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== test/tb.sv =====
// Testbench for deque_with_value_search: a directed table, then random traffic
// with random idling on both sides, each response checked against a shadow deque or a typed one.
// Depends on dqs_pkg and the deque_with_value_search RTL.
`timescale 1ns / 1ps

module tb;

    import dqs_pkg::*;

    // action codes the block must ignore
    localparam t_action ACT_SPARE_LO = t_action'(3'd6);
    localparam t_action ACT_SPARE_HI = t_action'(3'd7);

    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;    // quiet time after the last response
    localparam int N_STEPS      = 25;

    // values that keep finds and removes hitting
    localparam logic [31:0] POOL [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0006, 32'h0000_0007
    };

    // one row of the directed table; reps applies the request that many times,
    // typed selects the hand-written response over the predicted one
    typedef struct packed {
        t_req       req;
        logic [4:0] reps;
        logic       typed;
        t_rsp       rsp;
    } t_step;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    localparam t_rsp NO_RSP = '0;

    t_step directed [N_STEPS] = '{
        // empty list: every removal reports empty, find reports not found
        '{'{ACT_POP_BACK,   32'h0000_0000}, 5'd1,  1'b1, '{ST_EMPTY, 32'h0, 4'd0, 5'd0}},
        '{'{ACT_POP_FRONT,  32'h0000_0000}, 5'd1,  1'b1, '{ST_EMPTY, 32'h0, 4'd0, 5'd0}},
        '{'{ACT_REMOVE,     32'h0000_0000}, 5'd1,  1'b1, '{ST_EMPTY, 32'h0, 4'd0, 5'd0}},
        '{'{ACT_FIND,       32'hFFFF_FFFF}, 5'd1,  1'b1, '{ST_NOT_FOUND, 32'h0, 4'd0, 5'd0}},
        // unused codes: ok, nothing changes
        '{'{ACT_SPARE_LO,   32'h5A5A_5A5A}, 5'd1,  1'b1, '{ST_OK, 32'h0, 4'd0, 5'd0}},
        '{'{ACT_SPARE_HI,   32'hFFFF_FFFF}, 5'd1,  1'b1, '{ST_OK, 32'h0, 4'd0, 5'd0}},
        '{'{ACT_PUSH_BACK,  32'h0000_0000}, 5'd1,  1'b1, '{ST_OK, 32'h0, 4'd0, 5'd1}},
        '{'{ACT_PUSH_BACK,  32'hFFFF_FFFF}, 5'd1,  1'b1, '{ST_OK, 32'h0, 4'd0, 5'd2}},
        '{'{ACT_PUSH_FRONT, 32'h8000_0000}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_FIND,       32'hFFFF_FFFF}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_FIND,       32'h1234_5678}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_REMOVE,     32'h0000_0000}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_REMOVE,     32'hDEAD_BEEF}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_POP_BACK,   32'h0000_0000}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_POP_FRONT,  32'h0000_0000}, 5'd1,  1'b0, NO_RSP},
        // drained by pops: must read as empty again
        '{'{ACT_POP_BACK,   32'h0000_0000}, 5'd1,  1'b1, '{ST_EMPTY, 32'h0, 4'd0, 5'd0}},
        // fill to the brim, duplicates included
        '{'{ACT_PUSH_FRONT, 32'h0000_0001}, 5'd15, 1'b0, NO_RSP},
        '{'{ACT_PUSH_BACK,  32'h7FFF_FFFF}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_PUSH_BACK,  32'h0000_0000}, 5'd1,  1'b1, '{ST_FULL, 32'h0, 4'd0, 5'd16}},
        '{'{ACT_PUSH_FRONT, 32'hFFFF_FFFF}, 5'd1,  1'b1, '{ST_FULL, 32'h0, 4'd0, 5'd16}},
        '{'{ACT_FIND,       32'h7FFF_FFFF}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_REMOVE,     32'h0000_0001}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_FIND,       32'h7FFF_FFFF}, 5'd1,  1'b0, NO_RSP},
        '{'{ACT_POP_FRONT,  32'h0000_0000}, 5'd15, 1'b0, NO_RSP},
        '{'{ACT_FIND,       32'h0000_0001}, 5'd1,  1'b0, NO_RSP}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_req i_in        = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out;

    // shadow copy of the list contents, front at index 0
    logic [VALUE_BITS-1:0] shadow_list [DEPTH];
    int                    shadow_len = 0;

    t_rsp expected_rsp [$];
    int   fail_count   = 0;
    int   cycle_count  = 0;

    // shared pacing knobs: calm turns idling off on both sides,
    // hold_off_pending asks the receiver for one long stall
    logic calm             = 1'b0;
    logic hold_off_pending = 1'b0;

    deque_with_value_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Works out the response to one request and updates the shadow list.
    function automatic t_rsp predict_response(t_req r);
        t_rsp                  res;
        logic [VALUE_BITS-1:0] key;
        int                    hit;
        key = r.value[VALUE_BITS-1:0];
        res = '0;
        res.status = ST_OK;
        hit = -1;
        for (int k = 0; k < shadow_len; k++)
            if (hit < 0 && shadow_list[k] == key) hit = k;
        case (r.action)
            ACT_PUSH_BACK: begin
                if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_list[shadow_len] = key;
                    shadow_len++;
                end
            end
            ACT_POP_BACK: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_len--;
                    res.popped_value = 32'(shadow_list[shadow_len]);
                end
            end
            ACT_PUSH_FRONT: begin
                if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = shadow_len; k > 0; k--) shadow_list[k] = shadow_list[k-1];
                    shadow_list[0] = key;
                    shadow_len++;
                end
            end
            ACT_POP_FRONT: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int k = 0; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                end
            end
            ACT_REMOVE: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int k = hit; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                end
            end
            ACT_FIND: begin
                if (hit < 0) res.status = ST_NOT_FOUND;
                else res.position = 4'(hit);
            end
            default: ;
        endcase
        res.entry_count = 5'(shadow_len);
        return res;
    endfunction

    function automatic logic [31:0] pool_or_random();
        if ($urandom_range(0, 9) < 6) return POOL[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Called at a rising edge; returns at the edge where the request transfers.
    // Stall is sampled at the falling edge, where it already holds its value for
    // the coming rising edge, so the expectation is queued before the transfer.
    task automatic send_request(t_req r, logic typed, t_rsp typed_rsp);
        int unsigned gap;
        t_rsp        predicted;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(negedge i_clk); while (o_in_stall);
        predicted = predict_response(r);
        expected_rsp.push_back(typed ? typed_rsp : predicted);
        @(posedge i_clk);
    endtask

    // Drops valid and waits until every outstanding response has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_rsp.size() != 0);
    endtask

    initial begin : main
        t_req        req;
        t_mix        mix;
        int unsigned seg_left;
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int s = 0; s < N_STEPS; s++)
            repeat (directed[s].reps)
                send_request(directed[s].req, directed[s].typed, directed[s].rsp);

        // list is empty again; start the random part from a settled block
        wait_drained();

        seg_left = 0;
        mix      = MIX_GROW;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // segments that push the list toward full, toward empty, or neither
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 48);
                mix      = t_mix'($urandom_range(0, 2));
                calm     = ($urandom_range(0, 3) == 0);
            end
            seg_left--;

            if (n == 400) begin
                // long receiver hold-off while requests keep coming back to back
                calm             = 1'b1;
                hold_off_pending = 1'b1;
            end
            if (n == 900) wait_drained();

            push_pct = (mix == MIX_GROW) ? 65 : (mix == MIX_SHRINK) ? 20 : 40;
            pop_pct  = push_pct + (100 - push_pct) / 2;
            roll     = $urandom_range(0, 99);
            if (roll < 2) begin
                req.action = roll[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
                req.value  = $urandom;
            end else if (roll < push_pct) begin
                req.action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
                req.value  = pool_or_random();
            end else if (roll < pop_pct) begin
                req.action = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
                req.value  = $urandom;
            end else begin
                req.action = $urandom_range(0, 1) ? ACT_REMOVE : ACT_FIND;
                // mostly a key that is present, so removes close real gaps
                if (shadow_len > 0 && $urandom_range(0, 3) != 0)
                    req.value = 32'(shadow_list[$urandom_range(0, shadow_len - 1)]);
                else
                    req.value = pool_or_random();
            end
            send_request(req, 1'b0, NO_RSP);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("deque_with_value_search verification clean");
        else
            $display("deque_with_value_search verification failed");
        $finish;
    end

    // Response side: random stall before each transfer, one long hold-off on request.
    initial begin : receiver
        int unsigned stall_cycles;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall_cycles     = HOLD_CYCLES;
            end else begin
                stall_cycles = calm ? 0 : $urandom_range(0, 12);
            end
            if (stall_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(negedge i_clk); while (!o_out_valid);
            @(posedge i_clk);
        end
    end

    // A response that is valid and not stalled at the falling edge transfers at
    // the next rising edge; compare it against the oldest expectation.
    always @(negedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rsp.size() == 0) begin
                $error("response with none outstanding: status %0d count %0d",
                       o_out.status, o_out.entry_count);
                fail_count++;
            end else begin
                want = expected_rsp.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    fail_count++;
                end
                if (o_out.popped_value !== want.popped_value) begin
                    $error("popped_value: expected %h, got %h",
                           want.popped_value, o_out.popped_value);
                    fail_count++;
                end
                if (o_out.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_out.position);
                    fail_count++;
                end
                if (o_out.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_out.entry_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("deque_with_value_search verification failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
src/dqs_pkg.sv
src/dqs_cell.sv
src/deque_with_value_search.sv
test/tb.sv
